>>> design/kfr_pkg.sv
// ----------------------------------------------------------------------------
// kfr_pkg: shared types and round logic for the keccak-f[1600] round block
// lane layout, command codes, rotation offsets and the one-round function
// ----------------------------------------------------------------------------
package kfr_pkg;

    localparam int LANES     = 25;
    localparam int LANE_W    = 64;
    localparam int IDX_W     = 5;
    localparam int CMD_W     = 2;
    // lane_index, lane_value, round_const packed, padded to whole bytes
    localparam int TDATA_W   = 136;
    localparam int TUSER_W   = 2;

    typedef logic [LANE_W-1:0]            t_lane;
    typedef logic [LANES-1:0][LANE_W-1:0] t_state;

    typedef enum logic [CMD_W-1:0] {
        CMD_WRITE = 2'd0,
        CMD_ROUND = 2'd1,
        CMD_READ  = 2'd2
    } t_cmd;

    // rotation offsets indexed [x][y]
    localparam logic [5:0] ROT_OFFSET [5][5] = '{
        '{6'd0,  6'd36, 6'd3,  6'd41, 6'd18},
        '{6'd1,  6'd44, 6'd10, 6'd45, 6'd2 },
        '{6'd62, 6'd6,  6'd43, 6'd15, 6'd61},
        '{6'd28, 6'd55, 6'd25, 6'd21, 6'd56},
        '{6'd27, 6'd20, 6'd39, 6'd8,  6'd14}
    };

    function automatic t_lane rotl(input t_lane v, input logic [5:0] n);
        t_lane r;
        if (n == 6'd0) begin
            r = v;
        end else begin
            r = (v << n) | (v >> (7'd64 - {1'b0, n}));
        end
        return r;
    endfunction

    // theta, rho+pi, chi, iota over the whole state
    function automatic t_state keccak_round(input t_state s, input t_lane rc);
        logic [4:0][LANE_W-1:0] par;
        logic [4:0][LANE_W-1:0] mix;
        t_state a;
        t_state moved;
        t_state res;
        for (int x = 0; x < 5; x++) begin
            par[x] = s[x] ^ s[x+5] ^ s[x+10] ^ s[x+15] ^ s[x+20];
        end
        for (int x = 0; x < 5; x++) begin
            mix[x] = par[(x+4)%5] ^ rotl(par[(x+1)%5], 6'd1);
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                a[x+5*y] = s[x+5*y] ^ mix[x];
            end
        end
        // lane (x,y) moves to (y, 2x+3y mod 5)
        for (int x = 0; x < 5; x++) begin
            for (int y = 0; y < 5; y++) begin
                moved[y+5*((2*x+3*y)%5)] = rotl(a[x+5*y], ROT_OFFSET[x][y]);
            end
        end
        for (int y = 0; y < 5; y++) begin
            for (int x = 0; x < 5; x++) begin
                res[x+5*y] = moved[x+5*y]
                           ^ (~moved[(x+1)%5+5*y] & moved[(x+2)%5+5*y]);
            end
        end
        res[0] = res[0] ^ rc;
        return res;
    endfunction

endpackage

>>> design/keccak_f1600_round.sv
// ----------------------------------------------------------------------------
// keccak_f1600_round: keccak-f[1600] state with lane access and round command
// holds 25 lanes of 64 bits; writes a lane, reads a lane or applies one round
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tuser: cmd; tdata: index, value, rc
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: read_value
//
// a round is the combinational xor/and/rotate network between the lane
// registers and their next value
// a read result is registered into the output register, or the skid if it is held
// a two-entry output (register plus skid) keeps requests flowing while a
// result waits; s_axis_tready drops only when both entries are full
// synchronous active-low reset clears all lanes to zero and empties the output
//
module keccak_f1600_round (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // tdata bits low to high: lane_index[4:0], lane_value[68:5],
    // round_const[132:69], zero pad [135:133]
    input  logic [kfr_pkg::TDATA_W-1:0] s_axis_tdata,
    // tuser bits low to high: cmd[1:0]
    input  logic [kfr_pkg::TUSER_W-1:0] s_axis_tuser,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // tdata bits low to high: read_value[63:0]
    output logic [kfr_pkg::LANE_W-1:0]  m_axis_tdata
);

    // request fields
    logic [kfr_pkg::CMD_W-1:0] in_cmd;
    logic [kfr_pkg::IDX_W-1:0] in_idx;
    kfr_pkg::t_lane            in_value;
    kfr_pkg::t_lane            in_rc;

    assign in_cmd   = s_axis_tuser[1:0];
    assign in_idx   = s_axis_tdata[4:0];
    assign in_value = s_axis_tdata[68:5];
    assign in_rc    = s_axis_tdata[132:69];

    // lane state
    kfr_pkg::t_state r_lanes;
    kfr_pkg::t_state n_lanes;

    // output register and skid stage
    logic           r_out_valid;
    logic           n_out_valid;
    kfr_pkg::t_lane r_out_data;
    kfr_pkg::t_lane n_out_data;
    logic           r_skid_valid;
    logic           n_skid_valid;
    kfr_pkg::t_lane r_skid_data;
    kfr_pkg::t_lane n_skid_data;

    logic           req_acc;
    logic           idx_ok;
    logic           push;
    logic           pop;
    kfr_pkg::t_lane rd_lane;

    assign s_axis_tready = !r_skid_valid;
    assign req_acc       = s_axis_tvalid && s_axis_tready;
    assign idx_ok        = (in_idx < kfr_pkg::IDX_W'(kfr_pkg::LANES));
    // out-of-range reads return zero
    assign rd_lane       = idx_ok ? r_lanes[in_idx] : '0;
    assign pop           = r_out_valid && m_axis_tready;

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // command decode and state update
    always_comb begin
        n_lanes = r_lanes;
        push    = 1'b0;
        if (req_acc) begin
            case (in_cmd)
                kfr_pkg::CMD_WRITE: begin
                    // writes beyond the last lane are dropped
                    if (idx_ok) begin
                        n_lanes[in_idx] = in_value;
                    end
                end
                kfr_pkg::CMD_ROUND: begin
                    n_lanes = kfr_pkg::keccak_round(r_lanes, in_rc);
                end
                kfr_pkg::CMD_READ: begin
                    push = 1'b1;
                end
                default: begin
                    // unknown command: no effect, no result
                end
            endcase
        end
    end

    // output register / skid control
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_skid_valid = r_skid_valid;
        n_skid_data  = r_skid_data;
        if (r_skid_valid) begin
            // no request taken while skid is full
            if (pop) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end
        end else if (push) begin
            if (!r_out_valid || pop) begin
                n_out_valid = 1'b1;
                n_out_data  = rd_lane;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_data  = rd_lane;
            end
        end else if (pop) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lanes      <= '0;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_lanes      <= n_lanes;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    // skid entry is only ever filled behind a held output entry
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry valid while output entry empty");

    // a read taken with an empty output shows up in the next cycle
    a_read_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && in_cmd == kfr_pkg::CMD_READ && !r_out_valid) |=>
        (r_out_valid && r_out_data == $past(rd_lane)))
        else $error("read result missing from output register");

    // an in-range write lands in its lane
    a_write_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (req_acc && in_cmd == kfr_pkg::CMD_WRITE && idx_ok) |=>
        (r_lanes[$past(in_idx)] == $past(in_value)))
        else $error("lane write lost");

endmodule
